>>> rtl/dpmc_pkg.sv
// ----------------------------------------------------------------------------
// dpmc_pkg: shared types and constants for the decimated pattern match counter
// Register indexes, keep-mode codes, field widths and the cell control bundle.
// ----------------------------------------------------------------------------
package dpmc_pkg;

  localparam int CHAR_W      = 8;   // one string byte
  localparam int COUNT_OUT_W = 11;  // match_count field on the result
  localparam int PAT_BYTES   = 16;  // bytes held by pattern_low/pattern_high
  localparam int PAT_IDX_W   = 4;   // index into the pattern bytes
  localparam int LEN_W       = 5;   // pattern_length register
  localparam int MODE_W      = 2;   // keep_mode register
  localparam int CFG_W       = 64;  // widest register
  localparam int CFG_IDX_W   = 2;   // four registers

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd3;

  // keep_mode codes; the unused code keeps nothing as well
  localparam logic [MODE_W-1:0] KEEP_EVEN = 2'd0;
  localparam logic [MODE_W-1:0] KEEP_ODD  = 2'd1;
  localparam logic [MODE_W-1:0] KEEP_NONE = 2'd2;

  // per-transfer control broadcast to every cell
  typedef struct packed {
    logic shift;  // a kept byte enters the chain
    logic clear;  // end of string: drop window contents
  } dpmc_ctrl_t;

endpackage

>>> rtl/dpmc_cell.sv
// ----------------------------------------------------------------------------
// dpmc_cell: one window slot of the kept-byte chain
// Holds a byte and its valid flag, passes them on to the next slot on a shift
// and compares its post-shift contents against its expected pattern byte.
// ----------------------------------------------------------------------------
module dpmc_cell
  import dpmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dpmc_ctrl_t        ctrl,
  input  logic [CHAR_W-1:0] byte_in,
  input  logic              valid_in,
  input  logic [CHAR_W-1:0] expect_byte,
  input  logic              active,      // slot lies inside the pattern length
  output logic [CHAR_W-1:0] byte_out,
  output logic              valid_out,
  output logic              hit
);

  logic [CHAR_W-1:0] byte_r, byte_nxt;
  logic              valid_r, valid_nxt;
  logic              valid_shift;

  assign byte_nxt    = ctrl.shift ? byte_in : byte_r;
  assign valid_shift = ctrl.shift ? valid_in : valid_r;
  assign valid_nxt   = ctrl.clear ? 1'b0 : valid_shift;

  // inactive slots never block a match
  assign hit = !active || (valid_shift && (byte_nxt == expect_byte));

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign byte_out  = byte_r;
  assign valid_out = valid_r;

endmodule

>>> rtl/decimated_pattern_match_counter_unit.sv
// ----------------------------------------------------------------------------
// decimated_pattern_match_counter_unit: position-filtered substring counter
// Each input transfer's result is written into the output register as it is accepted.
// Throughput: 1 byte per cycle while results drain; cells shift and compare in one pass.
// Reset: synchronous active-low rst_n clears registers, window and count.
// ----------------------------------------------------------------------------
//
// Each input byte alternates the position parity. Depending on keep_mode the
// even or the odd positions are kept (or none). A kept byte enters a chain of
// MAX_PATTERN cells, cell 0 newest. Every cell compares its new contents with
// pattern byte (len-1-k), so the whole window is checked in parallel; the AND
// of all cell hits bumps a saturating match counter.
//
// The result register decouples the two sides: a new byte is taken whenever
// the result register is empty or drains in the same cycle.
// After a transfer with tlast the window, parity and count return to reset;
// configuration registers keep their values.
module decimated_pattern_match_counter_unit
  import dpmc_pkg::*;
#(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_MATCHES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] in_char
  input  logic                 in_tlast,   // in_last
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [7:0] kept_char, [18:8] match_count, zero pad
  output logic                 out_tuser,  // [0] was_kept
  output logic                 out_tlast   // out_last
);

  localparam int CNT_W = $clog2(MAX_MATCHES + 1);
  localparam int EXT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

  // ---------------- configuration registers ----------------
  logic [MODE_W-1:0] keep_mode_r;
  logic [LEN_W-1:0]  pat_len_r;
  logic [CFG_W-1:0]  pat_low_r;
  logic [CFG_W-1:0]  pat_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_mode_r <= KEEP_EVEN;
      pat_len_r   <= LEN_W'(1);
      pat_low_r   <= '0;
      pat_high_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEEP_MODE:    keep_mode_r <= cfg_wdata[MODE_W-1:0];
        REG_PATTERN_LEN:  pat_len_r   <= cfg_wdata[LEN_W-1:0];
        REG_PATTERN_LOW:  pat_low_r   <= cfg_wdata;
        REG_PATTERN_HIGH: pat_high_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective length: zero acts as one, clamp to the chain length
  logic [LEN_W-1:0] len_eff;
  always_comb begin
    if (pat_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (pat_len_r > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = pat_len_r;
    end
  end

  // pattern bytes, byte 0 is the oldest character of a match
  logic [2*CFG_W-1:0] pat_all;
  logic [CHAR_W-1:0]  pat_bytes [PAT_BYTES];
  assign pat_all = {pat_high_r, pat_low_r};
  always_comb begin
    for (int j = 0; j < PAT_BYTES; j++) begin
      pat_bytes[j] = pat_all[j*CHAR_W +: CHAR_W];
    end
  end

  // ---------------- handshake and filter ----------------
  logic out_valid_r, out_valid_nxt;
  logic in_fire;
  logic parity_r, parity_nxt;
  logic keep;
  dpmc_ctrl_t ctrl;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign keep = ((keep_mode_r == KEEP_EVEN) && !parity_r) ||
                ((keep_mode_r == KEEP_ODD)  &&  parity_r);

  assign ctrl.shift = in_fire && keep;
  assign ctrl.clear = in_fire && in_tlast;

  always_comb begin
    parity_nxt = parity_r;
    if (in_fire) begin
      parity_nxt = in_tlast ? 1'b0 : !parity_r;
    end
  end

  // ---------------- cell chain ----------------
  logic [CHAR_W-1:0]      cell_byte  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_valid;
  logic [MAX_PATTERN-1:0] cell_hit;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LEN_W-1:0]  pidx;
    logic [CHAR_W-1:0] chain_byte;
    logic              chain_valid;

    // slot k, counted from the newest byte, meets pattern byte len-1-k
    assign pidx = len_eff - LEN_W'(1) - LEN_W'(k);

    if (k == 0) begin : g_head
      assign chain_byte  = in_tdata[CHAR_W-1:0];
      assign chain_valid = 1'b1;
    end else begin : g_body
      assign chain_byte  = cell_byte[k-1];
      assign chain_valid = cell_valid[k-1];
    end

    dpmc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .byte_in     (chain_byte),
      .valid_in    (chain_valid),
      .expect_byte (pat_bytes[pidx[PAT_IDX_W-1:0]]),
      .active      (LEN_W'(k) < len_eff),
      .byte_out    (cell_byte[k]),
      .valid_out   (cell_valid[k]),
      .hit         (cell_hit[k])
    );
  end

  // ---------------- saturating match counter ----------------
  logic [CNT_W-1:0] count_r, count_nxt, count_upd;
  logic [EXT_W-1:0] count_ext;

  always_comb begin
    count_upd = count_r;
    if (keep && (&cell_hit) && (count_r < CNT_W'(MAX_MATCHES))) begin
      count_upd = count_r + CNT_W'(1);
    end
    count_nxt = count_r;
    if (in_fire) begin
      count_nxt = in_tlast ? '0 : count_upd;
    end
  end

  assign count_ext = EXT_W'(count_upd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      parity_r    <= parity_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- result register ----------------
  logic [CHAR_W-1:0]      out_char_r;
  logic [COUNT_OUT_W-1:0] out_count_r;
  logic                   out_kept_r;
  logic                   out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_kept_r  <= keep;
      out_char_r  <= keep ? in_tdata[CHAR_W-1:0] : '0;
      out_count_r <= count_ext[COUNT_OUT_W-1:0];
      out_last_r  <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_count_r, out_char_r};
  assign out_tuser  = out_kept_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/dpmc_checker.sv
// ----------------------------------------------------------------------------
// dpmc_checker: port-level checks for the pattern match counter
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module dpmc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // every input transfer shows up as a result the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("input transfer produced no result");

  // input is only held off by a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without back-pressure");

  // a dropped byte reports a zero character
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0)
    else $error("dropped byte carries a character");

endmodule

bind decimated_pattern_match_counter_unit dpmc_checker u_dpmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for decimated_pattern_match_counter_unit
// Drives byte strings over the input stream under several keep modes and
// pattern settings, predicts each result transfer and checks it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import dpmc_pkg::*;

  localparam int MAX_PAT     = 16;
  localparam int MAX_HITS    = 1024;
  localparam int CYCLE_LIMIT = 400000;  // several times the slowest legal run
  localparam int HOLD_CYCLES = 160;     // long receiver hold-off
  localparam int FINAL_WAIT  = 1000;    // drain bound at the end
  localparam int RANDOM_ITEMS = 860;
  localparam int RUN_BYTES   = 300;     // one long string of repeated matches
  localparam int DIR_ROWS    = 30;

  // keep_mode code without a package name; the block treats it as keep-nothing
  localparam logic [MODE_W-1:0] KEEP_UNUSED = 2'd3;

  // receiver stall styles
  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_style_t;

  // one result transfer as the predictor sees it
  typedef struct packed {
    logic                   kept;
    logic [CHAR_W-1:0]      ch;
    logic [COUNT_OUT_W-1:0] count;
    logic                   last;
  } byte_result_t;

  // directed row: either a register write or one byte, optionally with a
  // hand-typed expected result
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     value;
    logic [CHAR_W-1:0]    ch;
    bit                   last;
    bit                   typed;
    byte_result_t         exp;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // [7:0] in_char
  logic                 in_tlast;   // in_last
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;  // [7:0] kept_char, [18:8] match_count, zero pad
  logic                 out_tuser;  // [0] was_kept
  logic                 out_tlast;  // out_last

  decimated_pattern_match_counter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // --------------------------------------------------------------------------
  // Shadow of the block: register copies plus window, parity, fill and count
  // --------------------------------------------------------------------------
  logic [MODE_W-1:0] mode_sh   = KEEP_EVEN;
  logic [LEN_W-1:0]  len_sh    = 5'd1;
  logic [CFG_W-1:0]  pat_lo_sh = '0;
  logic [CFG_W-1:0]  pat_hi_sh = '0;
  logic              parity    = 1'b0;
  logic [7:0]        win_bytes [MAX_PAT] = '{default: 8'h00};
  int                win_fill    = 0;
  int                match_tally = 0;

  byte_result_t pending_results [$];  // expected results, oldest first

  int errors       = 0;
  int results_seen = 0;
  int items_sent   = 0;
  int strings_sent = 0;
  int kept_seen    = 0;
  int peak_count   = 0;
  int sat_seen     = 0;
  int burst_left   = 0;
  int cycle_count  = 0;
  bit hold_done    = 1'b0;

  // Directed table. Typed rows are obvious from the rules: first results after
  // reset, the keep-nothing codes, length zero acting as one, and an oversized
  // length acting as a full 16-byte window that can't fill in two bytes.
  dir_row_t dir_tab [DIR_ROWS] = '{
    // reset settings: keep even, length 1, pattern byte 0x00
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, 11'd1, 1'b0}},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'hFF, 1'b0, 1'b1, '{1'b0, 8'h00, 11'd1, 1'b0}},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'hFF, 1'b1, 1'b1, '{1'b1, 8'hFF, 11'd1, 1'b1}},
    // odd positions, "abc", all-ones upper pattern half
    '{1'b1, REG_KEEP_MODE,    64'(KEEP_ODD),         8'h00, 1'b0, 1'b0, '0},
    '{1'b1, REG_PATTERN_LEN,  64'd3,                 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, REG_PATTERN_LOW,  64'hFFFF_FFFF_FF63_6261, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h78, 1'b0, 1'b0, '0},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h61, 1'b0, 1'b0, '0},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h78, 1'b0, 1'b0, '0},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h62, 1'b0, 1'b0, '0},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h78, 1'b0, 1'b0, '0},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h63, 1'b0, 1'b0, '0},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h78, 1'b0, 1'b0, '0},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h61, 1'b1, 1'b0, '0},
    // unused mode code keeps nothing
    '{1'b1, REG_KEEP_MODE, 64'(KEEP_UNUSED), 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'hFF, 1'b0, 1'b1, '{1'b0, 8'h00, 11'd0, 1'b0}},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 11'd0, 1'b1}},
    '{1'b1, REG_KEEP_MODE, 64'(KEEP_NONE), 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h61, 1'b1, 1'b1, '{1'b0, 8'h00, 11'd0, 1'b1}},
    // length zero behaves as one
    '{1'b1, REG_KEEP_MODE,   64'(KEEP_EVEN), 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, REG_PATTERN_LEN, 64'd0,          8'h00, 1'b0, 1'b0, '0},
    '{1'b1, REG_PATTERN_LOW, 64'h0000_0000_0000_00FF, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'hFF, 1'b0, 1'b1, '{1'b1, 8'hFF, 11'd1, 1'b0}},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 11'd1, 1'b0}},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'hFF, 1'b1, 1'b1, '{1'b1, 8'hFF, 11'd2, 1'b1}},
    // register max length clamps to 16: a two-byte string never fills it
    '{1'b1, REG_PATTERN_LEN, 64'd31, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, REG_PATTERN_LOW, 64'd0,  8'h00, 1'b0, 1'b0, '0},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, 11'd0, 1'b0}},
    '{1'b0, REG_KEEP_MODE, 64'd0, 8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 11'd0, 1'b1}}
  };

  // Clock: 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result of one byte: filter by position parity, shift into the window,
  // compare the newest span bytes (oldest first) with the pattern.
  function automatic byte_result_t predict_filtered_count(input logic [7:0] ch,
                                                          input logic last);
    byte_result_t  r;
    int unsigned   span;
    logic          take;
    logic          hit;
    logic [127:0]  pat;
    span = (len_sh == 0) ? 1 : ((len_sh > MAX_PAT) ? MAX_PAT : len_sh);
    take = (mode_sh == KEEP_EVEN && !parity) || (mode_sh == KEEP_ODD && parity);
    pat  = {pat_hi_sh, pat_lo_sh};
    if (take) begin
      for (int k = MAX_PAT - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
      win_bytes[0] = ch;
      if (win_fill < MAX_PAT) win_fill++;
      hit = (win_fill >= span);
      for (int j = 0; j < span; j++) begin
        if (win_bytes[span-1-j] != pat[8*j +: 8]) hit = 1'b0;
      end
      if (hit && match_tally < MAX_HITS) match_tally++;
    end
    parity  = ~parity;
    r.kept  = take;
    r.ch    = take ? ch : 8'h00;
    r.count = match_tally[COUNT_OUT_W-1:0];
    r.last  = last;
    if (last) begin
      // end of string: everything but the registers returns to reset
      parity      = 1'b0;
      win_fill    = 0;
      match_tally = 0;
      foreach (win_bytes[k]) win_bytes[k] = 8'h00;
    end
    return r;
  endfunction

  // Offer one byte. The sender runs in bursts; a gap is inserted whenever a
  // burst is used up. The expectation is queued at the accepting edge.
  task automatic push_char(input logic [7:0] ch, input logic last, input bit typed,
                           input byte_result_t typed_res);
    byte_result_t pred;
    int           gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(12, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 24);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = ch;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    pred = predict_filtered_count(ch, last);
    pending_results.push_back(typed ? typed_res : pred);
    burst_left--;
    items_sent++;
    if (last) strings_sent++;
  endtask

  // Stop offering and let every queued result drain; the block has a single
  // result register, so it is idle once the queue is empty.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One register write; the shadow copy follows at the same edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    case (idx)
      REG_KEEP_MODE:    mode_sh   = value[MODE_W-1:0];
      REG_PATTERN_LEN:  len_sh    = value[LEN_W-1:0];
      REG_PATTERN_LOW:  pat_lo_sh = value;
      REG_PATTERN_HIGH: pat_hi_sh = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall style is redrawn when its run ends; one long hold-off
  // while the sender is busy, so the result register fills and in_tready drops.
  // --------------------------------------------------------------------------
  initial begin : receiver
    rx_style_t style;
    int        style_left;
    style      = RX_STREAM;
    style_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 400 && in_tvalid) begin
        hold_done  = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (style_left == 0) begin
        style      = rx_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(16, 96);
      end
      style_left--;
      case (style)
        RX_STREAM: out_tready = 1'b1;
        RX_COIN:   out_tready = 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready = ($urandom_range(0, 3) == 0);
        default:   out_tready = ~out_tready;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result check: every result transfer against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    byte_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] result transfer with nothing pending: tdata=%h tuser=%b tlast=%b",
                   $realtime, out_tdata, out_tuser, out_tlast);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.kept || out_tdata[7:0] !== want.ch ||
            out_tdata[18:8] !== want.count || out_tlast !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] result mismatch: kept %b/%b char %h/%h count %0d/%0d last %b/%b",
                     $realtime, want.kept, out_tuser, want.ch, out_tdata[7:0],
                     want.count, out_tdata[18:8], want.last, out_tlast);
        end
        if (want.kept) kept_seen++;
        if (want.count > peak_count) peak_count = want.count;
        if (want.count == MAX_HITS) sat_seen++;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, pending_results.size());
    $display("decimated_pattern_match_counter_unit verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed table, a long matching string, then random phases
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_W-1:0]  val;
    logic [127:0]      pat;
    logic [7:0]        alpha0;
    logic [7:0]        alpha1;
    logic [7:0]        ch;
    logic [MODE_W-1:0] mode_pick;
    logic [LEN_W-1:0]  len_pick;
    int                span;
    int                slen;
    int                ptr;
    int                nstr;
    int                r;
    int                random_items;
    int                phase;
    int                waited;
    bit                well;
    bit                take;

    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_KEEP_MODE;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tlast   = 1'b0;
    random_items = 0;
    phase      = 0;
    alpha0     = 8'h00;
    alpha1     = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows; register writes only once the block is idle
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].value);
      end else begin
        push_char(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].exp);
      end
    end

    // long string, length 1, every even byte matches: the count climbs high
    wait_idle();
    write_reg(REG_KEEP_MODE, 64'(KEEP_EVEN));
    write_reg(REG_PATTERN_LEN, 64'd1);
    write_reg(REG_PATTERN_LOW, 64'h5A);
    for (int i = 0; i < RUN_BYTES; i++) begin
      ch = (i % 2 == 0) ? 8'h5A : 8'($urandom);
      push_char(ch, i == RUN_BYTES - 1, 1'b0, '0);
    end

    // random phases: new settings, then a handful of strings that mostly
    // walk the pattern through the kept positions
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      r = $urandom_range(0, 99);
      mode_pick = (r < 45) ? KEEP_EVEN : (r < 90) ? KEEP_ODD :
                  (r < 95) ? KEEP_NONE : KEEP_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 60)      len_pick = LEN_W'($urandom_range(1, 4));
      else if (r < 85) len_pick = LEN_W'($urandom_range(5, 16));
      else if (r < 92) len_pick = 5'd0;
      else             len_pick = LEN_W'($urandom_range(17, 31));
      // small alphabets give repeats and overlapping matches
      case ($urandom_range(0, 4))
        0: begin alpha0 = 8'h00; alpha1 = 8'h00; end
        1: begin alpha0 = 8'hFF; alpha1 = 8'hFF; end
        default: begin alpha0 = 8'($urandom); alpha1 = 8'($urandom); end
      endcase
      // unused upper bits of mode and length writes carry noise
      if (phase == 0 || $urandom_range(0, 9) < 7) begin
        val = {$urandom, $urandom};
        val[MODE_W-1:0] = mode_pick;
        write_reg(REG_KEEP_MODE, val);
      end
      if (phase == 0 || $urandom_range(0, 9) < 7) begin
        val = {$urandom, $urandom};
        val[LEN_W-1:0] = len_pick;
        write_reg(REG_PATTERN_LEN, val);
      end
      for (int h = 0; h < 2; h++) begin
        if (phase == 0 || $urandom_range(0, 9) < 7) begin
          val = {$urandom, $urandom};
          if ($urandom_range(0, 1)) begin
            for (int j = 0; j < 8; j++) val[8*j +: 8] = $urandom_range(0, 1) ? alpha0 : alpha1;
          end
          write_reg(h == 0 ? REG_PATTERN_LOW : REG_PATTERN_HIGH, val);
        end
      end
      phase++;

      // strings follow whatever the registers now hold
      span = (len_sh == 0) ? 1 : ((len_sh > MAX_PAT) ? MAX_PAT : len_sh);
      pat  = {pat_hi_sh, pat_lo_sh};
      nstr = $urandom_range(2, 6);
      for (int s = 0; s < nstr; s++) begin
        slen = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 32) : $urandom_range(33, 80);
        well = ($urandom_range(0, 99) < 80);
        ptr  = 0;
        for (int i = 0; i < slen; i++) begin
          take = (mode_sh == KEEP_EVEN && i % 2 == 0) || (mode_sh == KEEP_ODD && i % 2 == 1);
          if (take && well && $urandom_range(0, 9) != 0) begin
            ch  = pat[8*ptr +: 8];
            ptr = (ptr + 1 == span) ? 0 : ptr + 1;
          end else begin
            ch = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? alpha0 : alpha1) : 8'($urandom);
            if (take && $urandom_range(0, 1)) ptr = 0;
          end
          push_char(ch, i == slen - 1, 1'b0, '0);
        end
        random_items += slen;
      end
    end

    // final drain, bounded
    @(negedge clk);
    in_tvalid = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < FINAL_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("run covered %0d bytes in %0d strings, %0d kept, %0d random phases",
             items_sent, strings_sent, kept_seen, phase);
    $display("peak match count %0d, %0d results at saturation, %0d mismatches",
             peak_count, sat_seen, errors);
    if (errors == 0) begin
      $display("decimated_pattern_match_counter_unit verification clean");
    end else begin
      $display("decimated_pattern_match_counter_unit verification failed");
    end
    $finish;
  end

endmodule
